@@ rtl/core/rhti_pkg.sv @@
// rhti_pkg: types and constants of the record hash table
// transaction payloads, status and kind codes, table geometry
// no dependencies
package rhti_pkg;

    localparam int TABLE_ENTRIES = 1024;              // power of two, 16 .. 65536
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int STR_BYTES     = 20;
    localparam int STR_W         = 8 * STR_BYTES;
    localparam int LEN_W         = $clog2(STR_BYTES + 1);
    localparam int SUM_W         = 13;                 // holds 19 signed bytes

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_FIND   = 1'b1;

    localparam logic [1:0] STATUS_INSERTED  = 2'd0;
    localparam logic [1:0] STATUS_OCCUPIED  = 2'd1;
    localparam logic [1:0] STATUS_FOUND     = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [63:0] name_0_7;
        logic [63:0] name_8_15;
        logic [31:0] name_16_19;
        logic [63:0] surname_0_7;
        logic [63:0] surname_8_15;
        logic [31:0] surname_16_19;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
        logic [63:0] balance;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] found_balance;
    } rsp_t;

    // one table slot as held in the record memory
    typedef struct packed {
        logic [STR_W-1:0] name;
        logic [STR_W-1:0] surname;
        logic [24:0]      date;
        logic [63:0]      balance;
    } record_t;

endpackage

@@ rtl/core/record_hash_table_insert_find.sv @@
// record_hash_table_insert_find: direct-mapped person record table, insert and find
// holds the valid-mark memory, the record memory and the sequencer around them
// depends on rhti_pkg
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  req     | in        | req_valid/req_ready  | req_t: kind, key fields, balance
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_t: status, found_balance
//
// one transaction at a time: accept, string scan, hash, memory read, decide and
// write back; the response register loads as the decide step ends, and the next
// request is taken in the idle state after it at the earliest
// the registered synchronous read of the two memories sets the read and decide steps
// after reset a sweep clears every valid mark, with req_ready low; the response
// register lets the next request in while a result waits
// a stalled response holds the sequencer in the decide step, so nothing is lost

module record_hash_table_insert_find
    import rhti_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_HASH,
        S_READ,
        S_CHECK
    } state_t;

    typedef struct packed {
        logic [LEN_W-1:0]        len;
        logic signed [SUM_W-1:0] sum;
    } scan_t;

    // length up to the first zero byte, and signed sum of bytes 1 .. len-1
    // the bytes are masked first, then summed in a balanced adder tree
    function automatic scan_t str_scan(input logic [STR_W-1:0] s);
        scan_t                  r;
        logic                   alive;
        logic [7:0]             b;
        logic [31:0][SUM_W-1:0] t;
        r.len = LEN_W'(STR_BYTES);
        r.sum = '0;
        t     = '0;
        alive = 1'b1;
        for (int i = 0; i < STR_BYTES; i++)
        begin
            b = s[8*i +: 8];
            if (alive && (b == 8'd0))
            begin
                r.len = LEN_W'(i);
            end
            alive = alive && (b != 8'd0);
            if (alive && (i > 0))
            begin
                t[i] = {{(SUM_W-8){b[7]}}, b};
            end
        end
        for (int w = 16; w > 0; w = w >> 1)
        begin
            for (int j = 0; j < w; j++)
            begin
                t[j] = t[2*j] + t[2*j+1];
            end
        end
        r.sum = $signed(t[0]);
        return r;
    endfunction

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     clr_cnt_reg, clr_cnt_next;
    req_t                 item_reg, item_next;
    scan_t                nscan_reg, nscan_next;
    scan_t                sscan_reg, sscan_next;
    logic [IDX_W-1:0]     slot_reg, slot_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;

    // memories
    logic                 vld_mem [TABLE_ENTRIES];
    record_t              rec_mem [TABLE_ENTRIES];
    logic                 vld_rd_reg;
    record_t              rec_rd_reg;

    logic                 vld_we;
    logic [IDX_W-1:0]     vld_waddr;
    logic                 vld_wdata;
    logic                 rec_we;
    record_t              rec_wdata;

    logic [STR_W-1:0]     item_name;
    logic [STR_W-1:0]     item_surname;
    logic [24:0]          item_date;
    logic [31:0]          hash;
    logic                 rsp_load;
    logic                 key_match;

    assign item_name    = {item_reg.name_16_19, item_reg.name_8_15, item_reg.name_0_7};
    assign item_surname = {item_reg.surname_16_19, item_reg.surname_8_15,
                           item_reg.surname_0_7};
    assign item_date    = {item_reg.year, item_reg.month, item_reg.day};

    // wrapping 32-bit hash: year times name sum, plus day times name length, plus surname sum
    assign hash = 32'(32'(item_reg.year) * 32'(nscan_reg.sum))
                + 32'(item_reg.day) * 32'(nscan_reg.len)
                + 32'(sscan_reg.sum);

    assign key_match = vld_rd_reg
                    && (rec_rd_reg.name == item_name)
                    && (rec_rd_reg.surname == item_surname)
                    && (rec_rd_reg.date == item_date);

    // in the decide step, the response register is free or is being emptied this cycle
    assign rsp_load = (state_reg == S_CHECK) && (!rsp_valid_reg || rsp_ready);

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // write ports: clearing sweep, or an insert into an empty slot
    always_comb
    begin
        rec_wdata.name    = item_name;
        rec_wdata.surname = item_surname;
        rec_wdata.date    = item_date;
        rec_wdata.balance = item_reg.balance;
        rec_we    = rsp_load && (item_reg.kind == KIND_INSERT) && !vld_rd_reg;
        vld_we    = (state_reg == S_CLEAR) || rec_we;
        vld_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : slot_reg;
        vld_wdata = (state_reg != S_CLEAR);
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        item_next      = item_reg;
        nscan_next     = nscan_reg;
        sscan_next     = sscan_reg;
        slot_next      = slot_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(TABLE_ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                nscan_next = str_scan(item_name);
                sscan_next = str_scan(item_surname);
                state_next = S_HASH;
            end
            S_HASH:
            begin
                // table size is a power of two, so the modulo is the low bits
                slot_next  = hash[IDX_W-1:0];
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (rsp_load)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.found_balance = '0;
                    if (item_reg.kind == KIND_INSERT)
                    begin
                        rsp_next.status = vld_rd_reg ? STATUS_OCCUPIED : STATUS_INSERTED;
                    end
                    else if (key_match)
                    begin
                        rsp_next.status        = STATUS_FOUND;
                        rsp_next.found_balance = rec_rd_reg.balance;
                    end
                    else
                    begin
                        rsp_next.status = STATUS_NOT_FOUND;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            item_reg      <= '0;
            nscan_reg     <= '0;
            sscan_reg     <= '0;
            slot_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            item_reg      <= item_next;
            nscan_reg     <= nscan_next;
            sscan_reg     <= sscan_next;
            slot_reg      <= slot_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    // valid-mark memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (vld_we)
        begin
            vld_mem[vld_waddr] <= vld_wdata;
        end
        vld_rd_reg <= vld_mem[slot_reg];
    end

    // record memory, written only on a successful insert
    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[slot_reg] <= rec_wdata;
        end
        rec_rd_reg <= rec_mem[slot_reg];
    end

    // one transaction in flight: no acceptance right after an acceptance
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while another is in flight");

    // balance is only shown with a found status
    a_balance_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != STATUS_FOUND)) |-> (rsp.found_balance == '0))
        else $error("nonzero balance without a match");

    // a record is only written over an empty slot
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        rec_we |-> (!vld_rd_reg && (state_reg == S_CHECK)))
        else $error("record written over an occupied slot");

    // a new response comes only out of the decide step
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> ($past(state_reg) == S_CHECK))
        else $error("response raised outside the decide step");

endmodule
